// File: rtl/core/rau_pkg.sv
// Package with shared types, constants and codes for the rational arithmetic unit.
package rau_pkg;

   localparam int DataWidth = 32;
   localparam int ProdWidth = 2 * DataWidth;
   localparam int CntWidth  = $clog2(ProdWidth + 1);

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ZERODEN = 2'd1,
      ST_DIVZERO = 2'd2,
      ST_OVFL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_ADD,
      S_GCD,
      S_DIVN_INIT,
      S_DIVN,
      S_DIVD_INIT,
      S_DIVD,
      S_CHECK,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic add;
      logic gcd_step;
      logic div_init_n;
      logic div_init_d;
      logic div_step;
      logic check;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic early_err;
      logic gcd_done;
      logic div_done;
   } stat_type;

endpackage

// File: rtl/core/rau_datapath.sv
// Datapath: operand decode, cross products, binary GCD and restoring divider.
module rau_datapath (
   input  logic                   clock,
   input  rau_pkg::cmd_type       cmd,
   input  logic [1:0]             req_type,
   input  logic [31:0]            num_a,
   input  logic [31:0]            den_a,
   input  logic [31:0]            num_b,
   input  logic [31:0]            den_b,
   output rau_pkg::stat_type      stat,
   output logic [31:0]            res_num,
   output logic [30:0]            res_den,
   output logic [1:0]             res_status
);
   import rau_pkg::*;

   localparam logic [ProdWidth-1:0] Lim = ProdWidth'(1) << (DataWidth - 1);

   logic [DataWidth-1:0] na_ff, da_ff, nb_ff, db_ff;
   logic                 nan_ff, dan_ff, nbn_ff, dbn_ff;
   op_type               op_ff;
   logic [ProdWidth-1:0] p1_ff, p2_ff, p3_ff;
   logic                 p1n_ff, p2n_ff, p3n_ff;
   logic [ProdWidth-1:0] nm_ff, dm_ff;
   logic                 neg_ff;
   logic [ProdWidth-1:0] gx_ff, gy_ff;
   logic [CntWidth-1:0]  gk_ff;
   logic [ProdWidth-1:0] g_ff;
   logic [ProdWidth-1:0] quo_ff, rem_ff;
   logic [CntWidth-1:0]  dcnt_ff;
   logic [31:0]          rn_ff;
   logic [30:0]          rd_ff;
   logic [1:0]           rs_ff;
   status_type           early_ff;

   // Sign and magnitude of one operand at the data width.
   function automatic logic [DataWidth:0] take(input logic [31:0] raw);
      logic [DataWidth-1:0] v;
      v = raw[DataWidth-1:0];
      take = {v[DataWidth-1], v[DataWidth-1] ? (~v + 1'b1) : v};
   endfunction

   logic [DataWidth:0] ta, tda, tb, tdb;
   assign ta  = take(num_a);
   assign tda = take(den_a);
   assign tb  = take(num_b);
   assign tdb = take(den_b);

   // Multiplier operands chosen by phase and operation.
   logic [DataWidth-1:0] mx, my;
   logic [ProdWidth-1:0] mprod;
   always_comb begin
      mx = na_ff;
      my = db_ff;
      if (cmd.mul2) begin
         unique case (op_ff)
            OP_ADD, OP_SUB: begin mx = nb_ff; my = da_ff; end
            OP_MUL:         begin mx = na_ff; my = nb_ff; end
            default:        begin mx = da_ff; my = nb_ff; end
         endcase
      end
   end
   assign mprod = ProdWidth'(mx) * ProdWidth'(my);

   // Signed add of the two cross products.
   logic [ProdWidth-1:0] amag;
   logic                 aneg;
   always_comb begin
      if (p1n_ff == p2n_ff) begin
         amag = p1_ff + p2_ff;
         aneg = p1n_ff;
      end else if (p1_ff >= p2_ff) begin
         amag = p1_ff - p2_ff;
         aneg = p1n_ff;
      end else begin
         amag = p2_ff - p1_ff;
         aneg = p2n_ff;
      end
   end

   // Restoring divide step.
   logic [ProdWidth:0]   trial;
   logic [ProdWidth-1:0] rsh;
   assign rsh   = {rem_ff[ProdWidth-2:0], quo_ff[ProdWidth-1]};
   assign trial = {rem_ff[ProdWidth-1], rsh} - {1'b0, g_ff};

   assign stat.early_err = (early_ff != ST_OK);
   assign stat.gcd_done  = (gx_ff == '0) || (gy_ff == '0) || (gx_ff == gy_ff);
   assign stat.div_done  = (dcnt_ff == '0);

   always_ff @(posedge clock) begin
      // Capture operands and the early error code.
      if (cmd.load) begin
         na_ff  <= ta[DataWidth-1:0];  nan_ff <= ta[DataWidth];
         da_ff  <= tda[DataWidth-1:0]; dan_ff <= tda[DataWidth];
         nb_ff  <= tb[DataWidth-1:0];
         nbn_ff <= tb[DataWidth] ^ (op_type'(req_type) == OP_SUB);
         db_ff  <= tdb[DataWidth-1:0]; dbn_ff <= tdb[DataWidth];
         op_ff  <= op_type'(req_type);
         if (tda[DataWidth-1:0] == '0 || tdb[DataWidth-1:0] == '0) begin
            early_ff <= ST_ZERODEN;
         end else if (op_type'(req_type) == OP_DIV && tb[DataWidth-1:0] == '0) begin
            early_ff <= ST_DIVZERO;
         end else begin
            early_ff <= ST_OK;
         end
      end
      // First products: na*db and the denominator product da*db.
      if (cmd.mul1) begin
         p1_ff  <= mprod;
         p1n_ff <= nan_ff ^ dbn_ff;
         p3_ff  <= ProdWidth'(da_ff) * ProdWidth'(db_ff);
         p3n_ff <= dan_ff ^ dbn_ff;
      end
      if (cmd.mul2) begin
         p2_ff <= mprod;
         unique case (op_ff)
            OP_ADD, OP_SUB: p2n_ff <= nbn_ff ^ dan_ff;
            OP_MUL:         p2n_ff <= nan_ff ^ nbn_ff;
            default:        p2n_ff <= dan_ff ^ nbn_ff;
         endcase
      end
      // Form numerator and denominator, seed the GCD.
      if (cmd.add) begin
         logic [ProdWidth-1:0] n, d;
         logic                 nn, dn;
         unique case (op_ff)
            OP_ADD, OP_SUB: begin n = amag;  nn = aneg;   d = p3_ff; dn = p3n_ff; end
            OP_MUL:         begin n = p2_ff; nn = p2n_ff; d = p3_ff; dn = p3n_ff; end
            default:        begin n = p1_ff; nn = p1n_ff; d = p2_ff; dn = p2n_ff; end
         endcase
         nm_ff  <= n;
         dm_ff  <= d;
         neg_ff <= (nn != dn) && (n != '0);
         gx_ff  <= n;
         gy_ff  <= d;
         gk_ff  <= '0;
      end
      // One binary GCD step.
      if (cmd.gcd_step) begin
         if (!gx_ff[0] && !gy_ff[0]) begin
            gx_ff <= gx_ff >> 1; gy_ff <= gy_ff >> 1; gk_ff <= gk_ff + 1'b1;
         end else if (!gx_ff[0]) begin
            gx_ff <= gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_ff <= gy_ff >> 1;
         end else if (gx_ff > gy_ff) begin
            gx_ff <= (gx_ff - gy_ff) >> 1;
         end else begin
            gy_ff <= (gy_ff - gx_ff) >> 1;
         end
      end
      // Start a division by the GCD.
      if (cmd.div_init_n || cmd.div_init_d) begin
         if (cmd.div_init_n) begin
            logic [ProdWidth-1:0] base;
            base = (gx_ff == '0) ? gy_ff : gx_ff;
            if (base == '0) begin
               g_ff <= ProdWidth'(1);
            end else begin
               g_ff <= base << gk_ff;
            end
            quo_ff <= nm_ff;
         end else begin
            quo_ff <= dm_ff;
         end
         rem_ff  <= '0;
         dcnt_ff <= CntWidth'(ProdWidth);
      end
      if (cmd.div_step) begin
         if (!trial[ProdWidth]) begin
            rem_ff <= trial[ProdWidth-1:0];
            quo_ff <= {quo_ff[ProdWidth-2:0], 1'b1};
         end else begin
            rem_ff <= rsh;
            quo_ff <= {quo_ff[ProdWidth-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 1'b1;
      end
      // Keep the reduced numerator once its division ends.
      if (cmd.div_init_d) begin
         nm_ff <= quo_ff;
      end
      // Range check and result formatting.
      if (cmd.check) begin
         logic [ProdWidth-1:0] sn;
         sn = neg_ff ? (~nm_ff + 1'b1) : nm_ff;
         if (early_ff != ST_OK) begin
            rn_ff <= '0; rd_ff <= '0; rs_ff <= early_ff;
         end else if (quo_ff > Lim - 1'b1 || (neg_ff ? nm_ff > Lim : nm_ff > Lim - 1'b1)) begin
            rn_ff <= '0; rd_ff <= '0; rs_ff <= ST_OVFL;
         end else begin
            rn_ff <= sn[31:0];
            rd_ff <= quo_ff[30:0];
            rs_ff <= ST_OK;
         end
      end
   end

   assign res_num    = rn_ff;
   assign res_den    = rd_ff;
   assign res_status = rs_ff;
endmodule

// File: rtl/core/rau_ctrl.sv
// Controller state machine sequencing the datapath for one beat at a time.
module rau_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  rau_pkg::stat_type  stat,
   output rau_pkg::cmd_type   cmd
);
   import rau_pkg::*;

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_MUL1;
         S_MUL1:      state_in = stat.early_err ? S_CHECK : S_MUL2;
         S_MUL2:      state_in = S_ADD;
         S_ADD:       state_in = S_GCD;
         S_GCD:       if (stat.gcd_done) state_in = S_DIVN_INIT;
         S_DIVN_INIT: state_in = S_DIVN;
         S_DIVN:      if (stat.div_done) state_in = S_DIVD_INIT;
         S_DIVD_INIT: state_in = S_DIVD;
         S_DIVD:      if (stat.div_done) state_in = S_CHECK;
         S_CHECK:     state_in = S_OUT;
         S_OUT:       if (!rsp_stall) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      cmd = '0;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_OUT);
      unique case (state_ff)
         S_IDLE:      cmd.load = req_valid;
         S_MUL1:      cmd.mul1 = 1'b1;
         S_MUL2:      cmd.mul2 = 1'b1;
         S_ADD:       cmd.add = 1'b1;
         S_GCD:       cmd.gcd_step = !stat.gcd_done;
         S_DIVN_INIT: cmd.div_init_n = 1'b1;
         S_DIVN:      cmd.div_step = !stat.div_done;
         S_DIVD_INIT: cmd.div_init_d = 1'b1;
         S_DIVD:      cmd.div_step = !stat.div_done;
         S_CHECK:     cmd.check = 1'b1;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit: adds, subtracts, multiplies or divides two fractions, reduced.
// The result is formed from cross products, a binary GCD loop and two 64-bit restoring
// divisions by the GCD. A zero denominator or a divide by zero skips the GCD loop and the
// divisions and goes straight to the range check and the result beat.
// Throughput: one beat at a time; a new request is taken the cycle after the result beat is accepted.
// Reset: synchronous, active high; returns the controller to idle, no result pending.
module rational_arithmetic_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] num_a,
   input  logic [31:0] den_a,
   input  logic [31:0] num_b,
   input  logic [31:0] den_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] res_num,
   output logic [30:0] res_den,
   output logic [1:0]  status
);
   import rau_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Arithmetic.
   rau_datapath u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .req_type   (req_type),
      .num_a      (num_a),
      .den_a      (den_a),
      .num_b      (num_b),
      .den_b      (den_b),
      .stat       (stat),
      .res_num    (res_num),
      .res_den    (res_den),
      .res_status (status)
   );
endmodule
